/* rtl/core/rtdt_pkg.sv */
package rtdt_pkg;

	// register map, decoded on paddr[2]
	localparam logic REG_NOMINAL   = 1'b0;
	localparam logic REG_REFERENCE = 1'b1;

	// pipeline geometry
	localparam int DIV1_BITS = 46;  // quotient bits of code*ref*2^15 / nominal
	localparam int ROOT_BITS = 31;  // result bits of the square root
	localparam int DIV2_BITS = 33;  // quotient bits of u*2^30 / (2^30 + s)
	localparam int POLY_ITER = 5;   // Horner steps

	localparam longint unsigned ONE_Q30 = 64'd1 << 30;

	// quadratic branch constants
	localparam logic [27:0] K_ROOT =
		28'(((64'd231000000 << 30) + 64'd763740444) / 64'd1527480889);
	localparam logic [25:0] G_SCALE =
		26'((64'd1310720000000 + 64'd19541) / 64'd39083);

	localparam logic signed [18:0] TEMP_MAX = 19'sd262143;
	localparam logic signed [18:0] TEMP_MIN = -19'sd262144;

	typedef logic signed [34:0] acc_t;

	// per-beat side data carried down the pipe
	typedef struct packed {
		logic        nom_zero;
		logic        quad;
		logic        ovf;
		logic        root_neg;
		logic [32:0] u;
		logic [29:0] y;
		acc_t        acc;
	} side_t;

	// polynomial coefficients c_n * 100^n in Q24
	function automatic acc_t poly_coef(input logic [2:0] idx);
		acc_t c;
		unique case (idx)
			3'd0: c = -$signed(35'(((64'd24202 << 24) + 64'd50) / 64'd100));
			3'd1: c = $signed(35'(((64'd22228 << 24) + 64'd50) / 64'd100));
			3'd2: c = $signed(35'(((64'd25859 << 24) + 64'd500) / 64'd1000));
			3'd3: c = -$signed(35'(((64'd48260 << 24) + 64'd5000) / 64'd10000));
			3'd4: c = -$signed(35'(((64'd28183 << 24) + 64'd5000) / 64'd10000));
			3'd5: c = $signed(35'(((64'd15243 << 24) + 64'd5000) / 64'd10000));
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

/* rtl/core/rtd_code_to_temperature.sv */
// Throughput: one beat per cycle while the output skid register is empty;
// the restoring dividers (one quotient bit per stage) and the square root
// (one root bit per stage) set the pipeline depth.
// A skid register at the output lets the pipe take one more beat while a result waits.
// Reset (arst_n low, asynchronous) clears all valid bits and loads the registers
// with nominal_ohms = 100 and reference_ohms = 430.
module rtd_code_to_temperature (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [14:0]         rtd_code,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [18:0]  temperature,
	output logic                out_of_range
);
	import rtdt_pkg::*;

	logic [15:0] nominal_q;
	logic [15:0] reference_q;
	logic        en;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q   <= 16'd100;
			reference_q <= 16'd430;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_NOMINAL:   nominal_q   <= pwdata[15:0];
				REG_REFERENCE: reference_q <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_NOMINAL:   prdata = {16'b0, nominal_q};
			REG_REFERENCE: prdata = {16'b0, reference_q};
		endcase
	end

	// ------------------------------------------------------------------
	// divider 1: x = code*ref*2^15 / nominal, one quotient bit per stage
	logic              d1_v_s   [DIV1_BITS+1];
	logic [30:0]       d1_num_s [DIV1_BITS+1];
	logic [15:0]       d1_rem_s [DIV1_BITS+1];
	logic [45:0]       d1_quo_s [DIV1_BITS+1];
	logic              d1_nz_s  [DIV1_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) d1_v_s[0] <= 1'b0;
		else if (en) d1_v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_num_s[0] <= 31'(rtd_code) * 31'(reference_q);
			d1_rem_s[0] <= '0;
			d1_quo_s[0] <= '0;
			d1_nz_s[0]  <= (nominal_q == 16'd0);
		end
	end

	for (genvar k = 0; k < DIV1_BITS; k++) begin : g_div1
		logic [45:0] n;
		logic [16:0] r;
		logic [16:0] diff;
		logic        ge;
		logic [45:0] qn;

		assign n    = {d1_num_s[k], 15'b0};
		assign r    = {d1_rem_s[k], n[DIV1_BITS-1-k]};
		assign ge   = (r >= {1'b0, nominal_q});
		assign diff = r - {1'b0, nominal_q};

		always_comb begin
			qn = d1_quo_s[k];
			qn[DIV1_BITS-1-k] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) d1_v_s[k+1] <= 1'b0;
			else if (en) d1_v_s[k+1] <= d1_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d1_num_s[k+1] <= d1_num_s[k];
				d1_rem_s[k+1] <= ge ? diff[15:0] : r[15:0];
				d1_quo_s[k+1] <= qn;
				d1_nz_s[k+1]  <= d1_nz_s[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// branch decode: quadratic when x >= 1, root argument negative when x >= 9
	logic        ps_v_s    [POLY_ITER+1];
	side_t       ps_side_s [POLY_ITER+1];
	logic [45:0] x_div;

	assign x_div = d1_quo_s[DIV1_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ps_v_s[0] <= 1'b0;
		else if (en) ps_v_s[0] <= d1_v_s[DIV1_BITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ps_side_s[0].nom_zero <= d1_nz_s[DIV1_BITS];
			ps_side_s[0].quad     <= (x_div[45:30] != 16'd0);
			ps_side_s[0].ovf      <= (x_div >= 46'(64'd9 * ONE_Q30));
			ps_side_s[0].root_neg <= 1'b0;
			ps_side_s[0].u        <= 33'(x_div - 46'(ONE_Q30));
			ps_side_s[0].y        <= x_div[29:0];
			ps_side_s[0].acc      <= poly_coef(3'd5);
		end
	end

	// ------------------------------------------------------------------
	// Horner steps: multiply stage, then round and add stage
	logic        pm_v_s    [POLY_ITER];
	side_t       pm_side_s [POLY_ITER];
	logic [62:0] pm_prod_s [POLY_ITER];
	logic        pm_neg_s  [POLY_ITER];

	for (genvar j = 0; j < POLY_ITER; j++) begin : g_poly
		acc_t        acc_in;
		logic        neg;
		acc_t        mag;
		logic [63:0] rsum;
		logic [33:0] rnd;
		acc_t        term;
		side_t       nx_side;

		assign acc_in = $signed(ps_side_s[j].acc);
		assign neg    = acc_in[34];
		assign mag    = neg ? -acc_in : acc_in;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) pm_v_s[j] <= 1'b0;
			else if (en) pm_v_s[j] <= ps_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pm_side_s[j] <= ps_side_s[j];
				pm_neg_s[j]  <= neg;
				pm_prod_s[j] <= 63'(mag[32:0]) * 63'(ps_side_s[j].y);
			end
		end

		assign rsum = 64'(pm_prod_s[j]) + 64'(ONE_Q30 >> 1);
		assign rnd  = rsum[63:30];
		assign term = pm_neg_s[j] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});

		always_comb begin
			nx_side     = pm_side_s[j];
			nx_side.acc = poly_coef(3'(POLY_ITER-1-j)) + term;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ps_v_s[j+1] <= 1'b0;
			else if (en) ps_v_s[j+1] <= pm_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) ps_side_s[j+1] <= nx_side;
		end
	end

	// ------------------------------------------------------------------
	// q = K*u / 2^30
	logic        km_v_s;
	side_t       km_side_s;
	logic [60:0] km_prod_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) km_v_s <= 1'b0;
		else if (en) km_v_s <= ps_v_s[POLY_ITER];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			km_side_s <= ps_side_s[POLY_ITER];
			km_prod_s <= 61'(K_ROOT) * 61'(ps_side_s[POLY_ITER].u);
		end
	end

	// ------------------------------------------------------------------
	// square root of (2^30 - q) * 2^30, one root bit per stage
	logic        sq_v_s    [ROOT_BITS+1];
	side_t       sq_side_s [ROOT_BITS+1];
	logic [30:0] sq_w_s    [ROOT_BITS+1];
	logic [32:0] sq_rem_s  [ROOT_BITS+1];
	logic [30:0] sq_root_s [ROOT_BITS+1];
	logic [30:0] q_val;
	side_t       sq_side_in;

	assign q_val = km_prod_s[60:30];

	// flag a negative root argument
	always_comb begin
		sq_side_in          = km_side_s;
		sq_side_in.root_neg = km_side_s.ovf || (q_val > 31'(ONE_Q30));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_v_s[0] <= 1'b0;
		else if (en) sq_v_s[0] <= km_v_s;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_side_s[0] <= sq_side_in;
			sq_w_s[0]    <= 31'(ONE_Q30) - q_val;
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
		localparam int B = ROOT_BITS - 1 - k;
		logic [61:0] v;
		logic [34:0] rsh;
		logic [34:0] trial;
		logic [34:0] diff;
		logic        ge;

		assign v     = {1'b0, sq_w_s[k], 30'b0};
		assign rsh   = {sq_rem_s[k], v[2*B+1 -: 2]};
		assign trial = {2'b0, sq_root_s[k], 2'b01};
		assign ge    = (rsh >= trial);
		assign diff  = rsh - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[k+1] <= 1'b0;
			else if (en) sq_v_s[k+1] <= sq_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_side_s[k+1] <= sq_side_s[k];
				sq_w_s[k+1]    <= sq_w_s[k];
				sq_rem_s[k+1]  <= ge ? diff[32:0] : rsh[32:0];
				sq_root_s[k+1] <= {sq_root_s[k][29:0], ge};
			end
		end
	end

	// ------------------------------------------------------------------
	// divider 2: rat = u*2^30 / (2^30 + s), one quotient bit per stage
	logic        dv_v_s    [DIV2_BITS+1];
	side_t       dv_side_s [DIV2_BITS+1];
	logic [31:0] dv_den_s  [DIV2_BITS+1];
	logic [31:0] dv_rem_s  [DIV2_BITS+1];
	logic [32:0] dv_quo_s  [DIV2_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else if (en) dv_v_s[0] <= sq_v_s[ROOT_BITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_side_s[0] <= sq_side_s[ROOT_BITS];
			dv_den_s[0]  <= 32'(ONE_Q30) + 32'(sq_root_s[ROOT_BITS]);
			dv_rem_s[0]  <= {2'b0, sq_side_s[ROOT_BITS].u[32:3]};
			dv_quo_s[0]  <= '0;
		end
	end

	for (genvar k = 0; k < DIV2_BITS; k++) begin : g_div2
		logic [62:0] d;
		logic [32:0] r;
		logic [32:0] diff;
		logic        ge;
		logic [32:0] qn;

		assign d    = {dv_side_s[k].u, 30'b0};
		assign r    = {dv_rem_s[k], d[DIV2_BITS-1-k]};
		assign ge   = (r >= {1'b0, dv_den_s[k]});
		assign diff = r - {1'b0, dv_den_s[k]};

		always_comb begin
			qn = dv_quo_s[k];
			qn[DIV2_BITS-1-k] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[k+1] <= 1'b0;
			else if (en) dv_v_s[k+1] <= dv_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_side_s[k+1] <= dv_side_s[k];
				dv_den_s[k+1]  <= dv_den_s[k];
				dv_rem_s[k+1]  <= ge ? diff[31:0] : r[31:0];
				dv_quo_s[k+1]  <= qn;
			end
		end
	end

	// ------------------------------------------------------------------
	// scale by 512/A
	logic        gm_v_s;
	side_t       gm_side_s;
	logic [58:0] gm_prod_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gm_v_s <= 1'b0;
		else if (en) gm_v_s <= dv_v_s[DIV2_BITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gm_side_s <= dv_side_s[DIV2_BITS];
			gm_prod_s <= 59'(G_SCALE) * 59'(dv_quo_s[DIV2_BITS]);
		end
	end

	// ------------------------------------------------------------------
	// rounding, branch select and saturation
	logic               fin_v_s;
	logic signed [18:0] fin_t_s;
	logic               fin_f_s;

	logic [59:0]        tq_sum;
	logic [21:0]        tq;
	acc_t               acc_f;
	logic               acc_neg;
	acc_t               acc_mag;
	logic [35:0]        tp_sum;
	logic [19:0]        tp_rnd;
	logic signed [20:0] tp;
	logic signed [18:0] t_next;
	logic               f_next;

	assign tq_sum  = 60'(gm_prod_s) + (60'd1 << 37);
	assign tq      = tq_sum[59:38];
	assign acc_f   = $signed(gm_side_s.acc);
	assign acc_neg = acc_f[34];
	assign acc_mag = acc_neg ? -acc_f : acc_f;
	assign tp_sum  = 36'(acc_mag) + 36'd32768;
	assign tp_rnd  = tp_sum[35:16];
	assign tp      = acc_neg ? -$signed({1'b0, tp_rnd}) : $signed({1'b0, tp_rnd});

	always_comb begin
		t_next = TEMP_MAX;
		f_next = 1'b1;
		priority if (gm_side_s.nom_zero) begin
			t_next = TEMP_MAX;
			f_next = 1'b1;
		end else if (gm_side_s.quad) begin
			if (!gm_side_s.root_neg && tq <= 22'd262143) begin
				t_next = $signed(tq[18:0]);
				f_next = 1'b0;
			end
		end else if (tp > 21'(TEMP_MAX)) begin
			t_next = TEMP_MAX;
			f_next = 1'b1;
		end else if (tp < 21'(TEMP_MIN)) begin
			t_next = TEMP_MIN;
			f_next = 1'b1;
		end else begin
			t_next = tp[18:0];
			f_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fin_v_s <= 1'b0;
		else if (en) fin_v_s <= gm_v_s;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_t_s <= t_next;
			fin_f_s <= f_next;
		end
	end

	// ------------------------------------------------------------------
	// output skid: catches the last stage when the beat is not taken
	logic               sk_v_q;
	logic signed [18:0] sk_t_q;
	logic               sk_f_q;

	assign en       = !sk_v_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sk_v_q <= 1'b0;
		end else if (sk_v_q) begin
			if (out_ready) sk_v_q <= 1'b0;
		end else if (fin_v_s && !out_ready) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!sk_v_q) begin
			sk_t_q <= fin_t_s;
			sk_f_q <= fin_f_s;
		end
	end

	assign out_valid    = sk_v_q || fin_v_s;
	assign temperature  = sk_v_q ? sk_t_q : fin_t_s;
	assign out_of_range = sk_v_q ? sk_f_q : fin_f_s;

endmodule
